[sv/scpa_pkg.sv]
// ----------------------------------------------------------------------------
// Size-class pool allocator package
// Shared field widths, command and status codes, sequencer states and the
// control structs passed between the allocator's modules.
// ----------------------------------------------------------------------------
package scpa_pkg;

	localparam int SIZE_W     = 20;
	localparam int ADDR_W     = 23;
	localparam int STATUS_W   = 3;
	localparam int CLASS_W    = 5;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 32;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK          = 3'd0,
		STATUS_TOO_LARGE   = 3'd1,
		STATUS_EXHAUSTED   = 3'd2,
		STATUS_NOT_IN_POOL = 3'd3,
		STATUS_UNDERFLOW   = 3'd4
	} status_t;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_READ,
		S_DONE
	} state_t;

	// Result of testing the current class against the request.
	typedef struct packed {
		logic fit;
		logic hit;
		logic is_last;
	} walk_flags_t;

	typedef struct packed {
		logic pop;
		logic push;
	} stack_ctrl_t;

endpackage

[sv/scpa_walker.sv]
// ----------------------------------------------------------------------------
// Size-class walker
// Steps through the classes one per cycle on advance, keeping the running class
// base, span and cell size, and tests the current class against the request.
// ----------------------------------------------------------------------------
module scpa_walker #(
	parameter int NUM_CLASSES     = 17,
	parameter int CELLS_PER_CLASS = 64,
	parameter int KW              = 5,
	parameter int AW              = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        advance,
	input  logic [scpa_pkg::SIZE_W-1:0] size,
	input  logic [scpa_pkg::ADDR_W-1:0] addr,
	output logic [KW-1:0]               k,
	output logic [AW-1:0]               base,
	output scpa_pkg::walk_flags_t       flags
);

	logic [KW-1:0] k_q;
	logic [AW-1:0] base_q;
	logic [AW-1:0] span_q;
	logic [AW-1:0] lastoff_q;
	logic [AW-1:0] csize_q;
	logic [AW-1:0] last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q       <= '0;
			base_q    <= '0;
			span_q    <= AW'(CELLS_PER_CLASS);
			lastoff_q <= AW'(CELLS_PER_CLASS - 1);
			csize_q   <= AW'(1);
		end else if (start) begin
			k_q       <= '0;
			base_q    <= '0;
			span_q    <= AW'(CELLS_PER_CLASS);
			lastoff_q <= AW'(CELLS_PER_CLASS - 1);
			csize_q   <= AW'(1);
		end else if (advance) begin
			// The next class starts right after this one and has cells twice as big.
			k_q       <= k_q + KW'(1);
			base_q    <= base_q + span_q;
			span_q    <= span_q << 1;
			lastoff_q <= lastoff_q << 1;
			csize_q   <= csize_q << 1;
		end
	end

	assign last = base_q + lastoff_q;

	always_comb begin
		if (size == '0) begin
			flags.fit = (k_q != '0);
		end else begin
			flags.fit = (csize_q >= AW'(size));
		end
		flags.hit     = (AW'(addr) >= base_q) && (AW'(addr) <= last);
		flags.is_last = (k_q == KW'(NUM_CLASSES - 1));
	end

	assign k    = k_q;
	assign base = base_q;

endmodule

[sv/scpa_stack.sv]
// ----------------------------------------------------------------------------
// Free stacks and counters
// Holds the per-class LIFO free stacks in one memory, the per-class used
// counts and the per-class fill marks that tell written entries from fresh.
// ----------------------------------------------------------------------------
module scpa_stack #(
	parameter int NUM_CLASSES = 17,
	parameter int KW          = 5,
	parameter int PW          = 6,
	parameter int UW          = 7
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [KW-1:0]               k,
	input  scpa_pkg::stack_ctrl_t       ctrl,
	input  logic [scpa_pkg::ADDR_W-1:0] push_addr,
	output logic [UW-1:0]               used,
	output logic                        fresh,
	output logic [scpa_pkg::ADDR_W-1:0] rd_data
);

	localparam int DEPTH = NUM_CLASSES << PW;

	logic [UW-1:0]               used_q [NUM_CLASSES];
	logic [UW-1:0]               fill_q [NUM_CLASSES];
	logic [scpa_pkg::ADDR_W-1:0] mem_q  [DEPTH];
	logic [scpa_pkg::ADDR_W-1:0] rd_q;
	logic [UW-1:0]               fill;
	logic [UW-1:0]               used_dec;

	assign used     = used_q[k];
	assign fill     = fill_q[k];
	assign used_dec = used - UW'(1);

	// An entry at or above the fill mark has never been pushed, so it holds no
	// valid address, which the sequencer computes instead.
	assign fresh = (used >= fill);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				used_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else if (ctrl.pop) begin
			used_q[k] <= used + UW'(1);
			if (used == fill) begin
				fill_q[k] <= fill + UW'(1);
			end
		end else if (ctrl.push) begin
			used_q[k] <= used_dec;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem_q[{k, used_dec[PW-1:0]}] <= push_addr;
		end
		if (ctrl.pop) begin
			rd_q <= mem_q[{k, used[PW-1:0]}];
		end
	end

	assign rd_data = rd_q;

endmodule

[sv/size_class_pool_allocator.sv]
// ----------------------------------------------------------------------------
// Size-class pool allocator
// Power-of-two segregated-fit allocator with a LIFO free stack per class.
// ----------------------------------------------------------------------------
// One transaction is processed at a time. The walker visits one size class
// per cycle, starting from the smallest class. An allocate pops the stack of
// the first class that fits and has a free cell and reads it in S_READ; a
// free pushes its address onto the class that holds it unless none of
// its cells is in use; a failed request visits every class. From S_DONE
// the result is loaded into the output register once that is free, and the
// sequencer is idle again from that same edge, so a new request is not taken
// before the last result has reached the output register. s_tready is high
// only while the sequencer is idle, and the next request is accepted while a
// result still waits in the output register. The free stack memory is not
// cleared after reset: per-class fill marks tell pushed entries from fresh
// ones, whose addresses are computed, so the block is ready right after reset.
// ----------------------------------------------------------------------------
module size_class_pool_allocator #(
	parameter int NUM_CLASSES     = 17,
	parameter int CELLS_PER_CLASS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// request_size [19:0], cell_address [42:20], zero [47:43]
	input  logic [scpa_pkg::IN_DATA_W-1:0]      s_tdata,
	// command [0]
	input  logic [0:0]                          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// status [2:0], granted_address [25:3], size_class [30:26], zero [31]
	output logic [scpa_pkg::OUT_DATA_W-1:0]     m_tdata
);

	localparam int KW  = $clog2(NUM_CLASSES);
	localparam int PW  = (CELLS_PER_CLASS > 1) ? $clog2(CELLS_PER_CLASS) : 1;
	localparam int UW  = $clog2(CELLS_PER_CLASS + 1);
	localparam int RAW = NUM_CLASSES + $clog2(CELLS_PER_CLASS) + 1;
	localparam int AW  = (RAW > scpa_pkg::ADDR_W) ? RAW : scpa_pkg::ADDR_W;

	scpa_pkg::state_t              state_q, state_d;
	scpa_pkg::cmd_t                cmd_q;
	logic [scpa_pkg::SIZE_W-1:0]   size_q;
	logic [scpa_pkg::ADDR_W-1:0]   addr_q;
	logic                          seen_fit_q;
	logic                          fresh_q;
	logic [PW-1:0]                 p_q;
	scpa_pkg::status_t             res_status_q, res_status_d;
	logic [scpa_pkg::ADDR_W-1:0]   res_addr_q, res_addr_d;
	logic [scpa_pkg::CLASS_W-1:0]  res_class_q, res_class_d;
	logic                          res_load;
	logic                          m_tvalid_q;
	logic [scpa_pkg::OUT_DATA_W-1:0] m_tdata_q;

	logic                          accept;
	logic                          walk_start;
	logic                          walk_advance;
	logic [KW-1:0]                 k;
	logic [AW-1:0]                 base;
	scpa_pkg::walk_flags_t         flags;
	scpa_pkg::stack_ctrl_t         ctrl;
	logic [UW-1:0]                 used;
	logic                          fresh;
	logic [scpa_pkg::ADDR_W-1:0]   rd_data;
	logic [AW-1:0]                 init_addr;
	logic                          out_free;

	assign accept     = s_tvalid && s_tready;
	assign walk_start = accept;
	assign out_free   = !m_tvalid_q || m_tready;
	assign init_addr  = base + (AW'(p_q) << k);

	scpa_walker #(
		.NUM_CLASSES     (NUM_CLASSES),
		.CELLS_PER_CLASS (CELLS_PER_CLASS),
		.KW              (KW),
		.AW              (AW)
	) u_walker (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (walk_start),
		.advance (walk_advance),
		.size    (size_q),
		.addr    (addr_q),
		.k       (k),
		.base    (base),
		.flags   (flags)
	);

	scpa_stack #(
		.NUM_CLASSES (NUM_CLASSES),
		.KW          (KW),
		.PW          (PW),
		.UW          (UW)
	) u_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.k         (k),
		.ctrl      (ctrl),
		.push_addr (addr_q),
		.used      (used),
		.fresh     (fresh),
		.rd_data   (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scpa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		walk_advance = 1'b0;
		ctrl         = '0;
		res_load     = 1'b0;
		res_status_d = scpa_pkg::STATUS_OK;
		res_addr_d   = '0;
		res_class_d  = '0;
		case (state_q)
			scpa_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = scpa_pkg::S_SCAN;
				end
			end
			scpa_pkg::S_SCAN: begin
				if (cmd_q == scpa_pkg::CMD_ALLOC) begin
					if (flags.fit && (used < UW'(CELLS_PER_CLASS))) begin
						ctrl.pop = 1'b1;
						state_d  = scpa_pkg::S_READ;
					end else if (flags.is_last) begin
						res_load = 1'b1;
						if (seen_fit_q || flags.fit) begin
							res_status_d = scpa_pkg::STATUS_EXHAUSTED;
						end else begin
							res_status_d = scpa_pkg::STATUS_TOO_LARGE;
						end
						state_d = scpa_pkg::S_DONE;
					end else begin
						walk_advance = 1'b1;
					end
				end else begin
					if (flags.hit) begin
						res_load    = 1'b1;
						res_class_d = scpa_pkg::CLASS_W'(k);
						if (used == '0) begin
							res_status_d = scpa_pkg::STATUS_UNDERFLOW;
						end else begin
							ctrl.push = 1'b1;
						end
						state_d = scpa_pkg::S_DONE;
					end else if (flags.is_last) begin
						res_load     = 1'b1;
						res_status_d = scpa_pkg::STATUS_NOT_IN_POOL;
						state_d      = scpa_pkg::S_DONE;
					end else begin
						walk_advance = 1'b1;
					end
				end
			end
			scpa_pkg::S_READ: begin
				res_load    = 1'b1;
				res_class_d = scpa_pkg::CLASS_W'(k);
				if (fresh_q) begin
					res_addr_d = init_addr[scpa_pkg::ADDR_W-1:0];
				end else begin
					res_addr_d = rd_data;
				end
				state_d = scpa_pkg::S_DONE;
			end
			scpa_pkg::S_DONE: begin
				if (out_free) begin
					state_d = scpa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = scpa_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= scpa_pkg::cmd_t'(s_tuser[0]);
			size_q <= s_tdata[19:0];
			addr_q <= s_tdata[42:20];
		end
		if (ctrl.pop) begin
			fresh_q <= fresh;
			p_q     <= used[PW-1:0];
		end
		if (res_load) begin
			res_status_q <= res_status_d;
			res_addr_q   <= res_addr_d;
			res_class_q  <= res_class_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_fit_q <= 1'b0;
		end else if (accept) begin
			seen_fit_q <= 1'b0;
		end else if (walk_advance && flags.fit) begin
			seen_fit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == scpa_pkg::S_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == scpa_pkg::S_DONE && out_free) begin
			m_tdata_q <= {1'b0, res_class_q, res_addr_q, res_status_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
